### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication: prop is checked in the cycle after cond holds
`define ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### design/itrd_pkg.sv
`default_nettype none

package itrd_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_BITS = 5;
    localparam int CHAR_BITS  = 7;
    localparam int DIGIT_BITS = 4;

    // quotient bits resolved per divider cycle
    localparam int STEP_BITS  = 8;
    localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W      = STEPS * STEP_BITS;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam int STACK_DEPTH = VALUE_BITS;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [RADIX_BITS-1:0] BASE_MIN     = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] BASE_MAX     = RADIX_BITS'(16);
    localparam logic [RADIX_BITS-1:0] BASE_DEFAULT = RADIX_BITS'(10);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(8'h30);
    localparam logic [CHAR_BITS-1:0] CHAR_A     = CHAR_BITS'(8'h41);
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = CHAR_BITS'(8'h2d);

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic [RADIX_BITS-1:0] base;
    } job_t;

    function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < DIGIT_BITS'(10))
        begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_BITS'(d) - CHAR_BITS'(10);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/itrd_front.sv
`default_nettype none

module itrd_front
    import itrd_pkg::*;
(
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic [RADIX_BITS-1:0]        radix,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output job_t                              push_job
);

    logic                  neg;
    logic [VALUE_BITS-1:0] raw;

    assign raw        = value;
    assign neg        = raw[VALUE_BITS-1];
    assign item_ready = push_ready;
    assign push_valid = item_valid;

    always_comb
    begin
        push_job.neg = neg;
        // unsigned negate, so the most negative value keeps its magnitude
        push_job.mag = neg ? (~raw + VALUE_BITS'(1)) : raw;
        if ((radix < BASE_MIN) || (radix > BASE_MAX))
        begin
            push_job.base = BASE_DEFAULT;
        end
        else
        begin
            push_job.base = radix;
        end
    end

endmodule

`default_nettype wire

### design/itrd_queue.sv
`default_nettype none

module itrd_queue
    import itrd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

`include "assert_macros.svh"

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + QUEUE_PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? (rd_ptr_reg + QUEUE_PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_CLK(a_queue_bound, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `ASSERT_NEXT(a_queue_ptr_gap, 1'b1,
        (count_reg == QUEUE_CNT_W'(1)) == ((wr_ptr_reg ^ rd_ptr_reg) == QUEUE_PTR_W'(1)),
        "queue pointers disagree with count")

endmodule

`default_nettype wire

### design/itrd_back.sv
`default_nettype none

module itrd_back
    import itrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire job_t              pop_job,
    output logic                   char_valid,
    input  wire logic              char_ready,
    output logic [CHAR_BITS-1:0]   char_code,
    output logic                   last
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [DIV_W-1:0]        quo_reg, quo_next;
    logic [DIGIT_BITS-1:0]   rem_reg, rem_next;
    logic [RADIX_BITS-1:0]   base_reg;
    logic                    sign_reg, sign_next;
    logic [STEP_CNT_W-1:0]   step_reg, step_next;
    logic [STACK_CNT_W-1:0]  sp_reg, sp_next;
    logic [DIGIT_BITS-1:0]   stack_reg [STACK_DEPTH];
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]    char_reg, char_next;
    logic                    last_reg, last_next;

    logic                    take_job;
    logic                    load_out;
    logic                    digit_done;
    logic [STEP_BITS-1:0]    chunk;
    logic [STEP_BITS-1:0]    qbits;
    logic [DIGIT_BITS-1:0]   chunk_rem;
    logic [DIV_W-1:0]        quo_shift;
    logic [STACK_IDX_W-1:0]  rd_idx;

    assign pop_ready  = (state_reg == ST_IDLE);
    assign take_job   = pop_valid && pop_ready;
    assign load_out   = (state_reg == ST_EMIT) && (!out_valid_reg || char_ready);
    assign digit_done = (state_reg == ST_DIV) && (step_reg == STEP_CNT_W'(STEPS - 1));
    assign chunk      = quo_reg[DIV_W-1 -: STEP_BITS];
    assign rd_idx     = STACK_IDX_W'(sp_reg - STACK_CNT_W'(1));

    assign char_valid = out_valid_reg;
    assign char_code  = char_reg;
    assign last       = last_reg;

    // restoring division, one slice of dividend bits per cycle
    always_comb
    begin
        logic [DIGIT_BITS:0] t;
        logic [DIGIT_BITS-1:0] r;
        r     = rem_reg;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, chunk[STEP_BITS-1-i]};
            if (t >= base_reg)
            begin
                t                       = t - base_reg;
                qbits[STEP_BITS-1-i]    = 1'b1;
            end
            r = t[DIGIT_BITS-1:0];
        end
        chunk_rem = r;
        quo_shift = (quo_reg << STEP_BITS) | DIV_W'(qbits);
    end

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        sign_next      = sign_reg;
        step_next      = step_reg;
        sp_next        = sp_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !char_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_job)
                begin
                    quo_next   = DIV_W'(pop_job.mag);
                    rem_next   = '0;
                    sign_next  = pop_job.neg;
                    step_next  = '0;
                    sp_next    = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next  = quo_shift;
                rem_next  = chunk_rem;
                step_next = step_reg + STEP_CNT_W'(1);
                if (digit_done)
                begin
                    // digit pushed, quotient feeds the next pass
                    rem_next  = '0;
                    step_next = '0;
                    sp_next   = sp_reg + STACK_CNT_W'(1);
                    if (quo_shift == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next = digit_to_char(stack_reg[rd_idx]);
                        last_next = (sp_reg == STACK_CNT_W'(1));
                        sp_next   = sp_reg - STACK_CNT_W'(1);
                        if (sp_reg == STACK_CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            sp_reg        <= '0;
            sign_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            sp_reg        <= sp_next;
            sign_reg      <= sign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (take_job)
        begin
            base_reg <= pop_job.base;
        end
        if (digit_done)
        begin
            stack_reg[sp_reg[STACK_IDX_W-1:0]] <= chunk_rem;
        end
    end

    `ASSERT_CLK(a_rem_below_base, (state_reg != ST_DIV) || (RADIX_BITS'(rem_reg) < base_reg),
        "remainder not below base")
    `ASSERT_CLK(a_stack_bound, sp_reg <= STACK_CNT_W'(STACK_DEPTH), "digit stack overflow")
    `ASSERT_NEXT(a_last_ends_job, load_out && last_next,
        (state_reg == ST_IDLE) && out_valid_reg && last_reg, "final character did not end job")
    `ASSERT_CLK(a_emit_has_digits, (state_reg != ST_EMIT) || (sp_reg != '0),
        "emitting with empty digit stack")

endmodule

`default_nettype wire

### design/integer_to_radix_digits.sv
// channel   signals                              transfer when
// item      item_valid item_ready value radix    item_valid && item_ready
// char      char_valid char_ready char_code last char_valid && char_ready
//
// a job leaves the queue for the back end, which divides the 32-bit magnitude by the base
// once per digit (8 quotient bits per cycle) and stacks each remainder, then emits the
// sign and the digits, most significant first, one character per transfer
// a two-entry queue takes new items while the back end is converting
// rst_n clears control state only; payload registers are not reset
// a stalled char_ready holds the output register and emitting; the next job may divide
`default_nettype none

module integer_to_radix_digits
    import itrd_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic [RADIX_BITS-1:0]        radix,
    output logic                              char_valid,
    input  wire logic                         char_ready,
    output logic [CHAR_BITS-1:0]              char_code,
    output logic                              last
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    itrd_front u_front
    (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .radix      (radix),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    itrd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    itrd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last       (last)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    import itrd_pkg::*;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0]        radix;
    } number_t;

    typedef struct {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
    } text_char_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_ready;
    logic signed [VALUE_BITS-1:0] value = '0;
    logic [RADIX_BITS-1:0]        radix = '0;
    logic                         char_valid;
    logic                         char_ready = 1'b0;
    logic [CHAR_BITS-1:0]         char_code;
    logic                         last;

    number_t    numbers_todo[$];
    text_char_t text_due[$];
    number_t    next_number;
    text_char_t got_char;

    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned quiet_cnt = 0;
    int unsigned items_taken = 0;
    int unsigned errors = 0;
    logic        quiet = 1'b0;
    logic        hold_off = 1'b0;

    integer_to_radix_digits i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .radix      (radix),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last       (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // expected text of one number, most significant character first
    function automatic void render_text(input logic signed [VALUE_BITS-1:0] v,
                                        input logic [RADIX_BITS-1:0] r);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] base;
        logic [DIGIT_BITS-1:0] digs[VALUE_BITS];
        logic                  neg;
        int                    nd;
        text_char_t            c;
        neg = v[VALUE_BITS-1];
        // unsigned negate keeps the most negative value exact
        mag = neg ? (~v + 1'b1) : v;
        base = (r < BASE_MIN || r > BASE_MAX) ? VALUE_BITS'(BASE_DEFAULT) : VALUE_BITS'(r);
        nd = 0;
        if (mag == 0)
        begin
            digs[0] = '0;
            nd = 1;
        end
        else
        begin
            while (mag != 0)
            begin
                digs[nd] = DIGIT_BITS'(mag % base);
                mag = mag / base;
                nd++;
            end
        end
        if (neg)
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            text_due.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            if (digs[k] < 10)
                c.code = CHAR_ZERO + CHAR_BITS'(digs[k]);
            else
                c.code = CHAR_A + CHAR_BITS'(digs[k] - 10);
            c.last = (k == 0);
            text_due.push_back(c);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 40);
            1: v = $urandom >> $urandom_range(0, 31);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 3) == 0)
            v = -v;
        return v;
    endfunction

    function automatic logic [RADIX_BITS-1:0] random_radix();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return RADIX_BITS'($urandom_range(2, 16));
        else if (r == 7)
            return ($urandom_range(0, 1) != 0) ? BASE_MIN : BASE_MAX;
        else
            return RADIX_BITS'($urandom_range(0, 31));
    endfunction

    task automatic queue_number(input logic [VALUE_BITS-1:0] v, input logic [RADIX_BITS-1:0] r);
        number_t n;
        n.value = v;
        n.radix = r;
        numbers_todo.push_back(n);
    endtask

    // stretches where neither side idles
    always @(posedge clk)
    begin
        if (quiet_cnt == 0)
        begin
            quiet <= ($urandom_range(0, 3) == 0);
            quiet_cnt <= $urandom_range(100, 400);
        end
        else
        begin
            quiet_cnt <= quiet_cnt - 1;
        end
    end

    // item driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                render_text(value, radix);
                items_taken <= items_taken + 1;
            end
            if (!item_valid || item_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    item_valid <= 1'b0;
                end
                else if (numbers_todo.size() != 0)
                begin
                    next_number = numbers_todo.pop_front();
                    item_valid <= 1'b1;
                    value <= next_number.value;
                    radix <= next_number.radix;
                    send_gap <= quiet ? 0 : pick_gap();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // character monitor and receiver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            char_ready <= 1'b0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                if (text_due.size() == 0)
                begin
                    $error("char_code: unexpected transfer, actual %0d last %0b", char_code, last);
                    errors++;
                end
                else
                begin
                    got_char = text_due.pop_front();
                    if (char_code !== got_char.code)
                    begin
                        $error("char_code: expected %0d, actual %0d", got_char.code, char_code);
                        errors++;
                    end
                    if (last !== got_char.last)
                    begin
                        $error("last: expected %0b, actual %0b", got_char.last, last);
                        errors++;
                    end
                end
            end
            if (hold_off)
            begin
                char_ready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                char_ready <= 1'b0;
            end
            else
            begin
                char_ready <= 1'b1;
                recv_gap <= quiet ? 0 : pick_gap();
            end
        end
    end

    // long receiver hold-off while items keep coming, so the input backs up
    initial
    begin
        wait (items_taken >= 60);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        // directed numbers: extremes, zero, every digit letter, bad bases
        queue_number(32'd0, 5'd10);
        queue_number(32'd0, 5'd2);
        queue_number(32'd1, 5'd2);
        queue_number(-32'sd1, 5'd10);
        queue_number(-32'sd1, 5'd16);
        queue_number(32'h7fff_ffff, 5'd2);
        queue_number(32'h8000_0000, 5'd2);
        queue_number(32'h7fff_ffff, 5'd10);
        queue_number(32'h8000_0000, 5'd10);
        queue_number(32'h8000_0000, 5'd16);
        queue_number(32'h7fff_ffff, 5'd16);
        queue_number(32'h8000_0000, 5'd3);
        queue_number(32'd255, 5'd16);
        queue_number(-32'sd43981, 5'd16);
        queue_number(32'hfedc_ba98, 5'd16);
        queue_number(32'd12345, 5'd0);
        queue_number(32'd12345, 5'd1);
        queue_number(-32'sd12345, 5'd17);
        queue_number(32'd99, 5'd31);
        queue_number(32'd35, 5'd3);
        queue_number(32'd63, 5'd8);
        queue_number(32'd10, 5'd11);
        queue_number(32'd100, 5'd15);
        queue_number(-32'sd7, 5'd7);
        repeat (156) queue_number(random_value(), random_radix());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (numbers_todo.size() != 0 || item_valid)
            @(posedge clk);
        while (text_due.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        if (errors == 0 && text_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
